// ===== src/base64_stream_decoder_defines.svh =====
// Assertion macros shared by the base64 stream decoder RTL.
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// Check that a condition implies a consequence in the same cycle.
`define B64D_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("base64 decoder check failed");
// Check that a condition implies a consequence in the next cycle.
`define B64D_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("base64 decoder check failed");
`else
`define B64D_ASSERT_SAME(label, clk, rst_n, cond, cons)
`define B64D_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif
`endif

// ===== src/b64d_pkg.sv =====
// Types and constants of the base64 stream decoder.
`default_nettype none
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] CHAR_LOWER = 8'h61;
  localparam logic [7:0] CHAR_DIGIT = 8'h30;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [5:0] LOWER_BASE = 6'd26;
  localparam logic [5:0] DIGIT_BASE = 6'd52;
  localparam logic [5:0] PLUS_VAL   = 6'd62;
  localparam logic [5:0] SLASH_VAL  = 6'd63;

  // Position within a group of four characters.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2,
    PH_FOURTH = 2'd3
  } phase_t;

  // Classification of one character.
  typedef struct packed {
    logic       pad;
    logic       bad;
    logic [5:0] value;
  } sextet_t;

  // Result of one decode step.
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       byte_valid;
    logic       final_result;
    logic       bad_char;
  } result_t;

endpackage
`default_nettype wire

// ===== src/b64d_sextet.sv =====
// Character classifier: maps an ASCII code to its 6-bit base64 value.
`default_nettype none
module b64d_sextet (
  input  wire logic [7:0]       char_code,
  output b64d_pkg::sextet_t     sextet
);
  import b64d_pkg::*;

  // Classify against the alphabet ranges
  always_comb begin
    sextet.pad   = (char_code == PAD_CHAR);
    sextet.bad   = 1'b0;
    sextet.value = '0;
    if (char_code inside {[8'h41:8'h5A]}) begin
      sextet.value = 6'(char_code - CHAR_UPPER);
    end else if (char_code inside {[8'h61:8'h7A]}) begin
      sextet.value = 6'(char_code - CHAR_LOWER) + LOWER_BASE;
    end else if (char_code inside {[8'h30:8'h39]}) begin
      sextet.value = 6'(char_code - CHAR_DIGIT) + DIGIT_BASE;
    end else if (char_code == CHAR_PLUS) begin
      sextet.value = PLUS_VAL;
    end else if (char_code == CHAR_SLASH) begin
      sextet.value = SLASH_VAL;
    end else if (char_code != PAD_CHAR) begin
      sextet.bad = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== src/b64d_step.sv =====
// Group sequencer: combines the stored sextet with the new one into bytes.
`default_nettype none
module b64d_step (
  input  wire b64d_pkg::phase_t  phase,
  input  wire logic [5:0]        prev_sextet,
  input  wire b64d_pkg::sextet_t sextet,
  input  wire logic              end_of_text,
  output b64d_pkg::phase_t       phase_nxt,
  output logic [5:0]             prev_nxt,
  output b64d_pkg::result_t      result
);
  import b64d_pkg::*;

  // Next group position and stored sextet
  always_comb begin
    phase_nxt = phase;
    prev_nxt  = prev_sextet;
    if (!sextet.pad) begin
      prev_nxt = sextet.value;
      case (phase)
        PH_FIRST:  phase_nxt = PH_SECOND;
        PH_SECOND: phase_nxt = PH_THIRD;
        PH_THIRD:  phase_nxt = PH_FOURTH;
        PH_FOURTH: phase_nxt = PH_FIRST;
        default:   phase_nxt = PH_FIRST;
      endcase
    end
    if (end_of_text) begin
      phase_nxt = PH_FIRST;
      prev_nxt  = '0;
    end
  end

  // Assemble the byte and result flags
  always_comb begin
    logic [7:0] data;
    logic       valid;
    data  = '0;
    valid = 1'b0;
    if (!sextet.pad) begin
      case (phase)
        PH_FIRST: begin
          data  = {sextet.value, 2'b00};
          valid = end_of_text;
        end
        PH_SECOND: begin
          data  = {prev_sextet, sextet.value[5:4]};
          valid = 1'b1;
        end
        PH_THIRD: begin
          data  = {prev_sextet[3:0], sextet.value[5:2]};
          valid = 1'b1;
        end
        PH_FOURTH: begin
          data  = {prev_sextet[1:0], sextet.value};
          valid = 1'b1;
        end
        default: begin
          data  = '0;
          valid = 1'b0;
        end
      endcase
    end
    result.data         = valid ? data : 8'h00;
    result.byte_valid   = valid;
    result.final_result = end_of_text;
    result.bad_char     = sextet.bad;
    result.emit         = valid || sextet.bad || end_of_text;
  end

endmodule
`default_nettype wire

// ===== src/base64_stream_decoder.sv =====
// Base64 stream decoder top level: input register, decode logic, result register.
//
// Usage:
//   The input channel takes one ASCII character per transaction on
//   in_char_code, with in_end_of_text high on the last character of a
//   string. The result channel gives at most one result per character:
//   a decoded byte (out_byte with out_byte_valid), a bad-character flag,
//   the final mark of a string, or several. Characters that complete no byte
//   and are neither bad nor last give none; '=' padding gives one only when last.
//   Path: a character accepted into the input register passes the decode
//   logic into the result register (two registers deep).
//   Throughput: one character per cycle unless out_stall holds a waiting
//   result; the decode logic between the two registers is combinational.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   decoder to the start of a group with a zero stored sextet.
//   When out_stall is high with a result waiting, the result holds and the
//   input register holds as well, whether or not its character gives a
//   result; while it is full the input side is stalled through in_stall.
`default_nettype none
`include "base64_stream_decoder_defines.svh"
module base64_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_final_result,
  output logic            out_bad_char
);
  import b64d_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_eot_r;
  phase_t     phase_r;
  phase_t     phase_nxt;
  logic [5:0] prev_r;
  logic [5:0] prev_nxt;
  logic       out_valid_r;
  result_t    out_r;
  sextet_t    sextet;
  result_t    result;
  logic       s2_ready;
  logic       s1_advance;

  // Classify the registered character
  b64d_sextet u_sextet (
    .char_code (s1_char_r),
    .sextet    (sextet)
  );

  // Decode against the group state
  b64d_step u_step (
    .phase       (phase_r),
    .prev_sextet (prev_r),
    .sextet      (sextet),
    .end_of_text (s1_eot_r),
    .phase_nxt   (phase_nxt),
    .prev_nxt    (prev_nxt),
    .result      (result)
  );

  // Handshake control
  assign s2_ready   = !out_valid_r || !out_stall;
  assign s1_advance = s1_valid_r && s2_ready;
  assign in_stall   = s1_valid_r && !s2_ready;

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char_r <= in_char_code;
      s1_eot_r  <= in_end_of_text;
    end
  end

  // Advance the group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      prev_r  <= '0;
    end else if (s1_advance) begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_r.data;
  assign out_byte_valid   = out_r.byte_valid;
  assign out_final_result = out_r.final_result;
  assign out_bad_char     = out_r.bad_char;

  // A result without a byte carries a zero byte
  `B64D_ASSERT_SAME(a_zero_byte, clk, rst_n, out_valid_r && !out_r.byte_valid, out_r.data == 8'h00)
  // A result with neither byte nor bad flag must be the final one
  `B64D_ASSERT_SAME(a_empty_is_final, clk, rst_n, out_valid_r && !out_r.byte_valid && !out_r.bad_char, out_r.final_result)
  // End of text returns the decoder to the start of a group
  `B64D_ASSERT_NEXT(a_eot_resets, clk, rst_n, s1_advance && s1_eot_r, phase_r == PH_FIRST && prev_r == 6'd0)

endmodule
`default_nettype wire
